>>> rtl/core/ipm_pkg.sv
// Shared types and constants for the inactivity power mode manager.
// Used by every module in rtl/core; depends on nothing.
package ipm_pkg;

   localparam int WordWidth        = 32;
   localparam int WeightWidth      = 10;
   localparam int CountWidth       = $clog2(WordWidth);
   localparam int EnergyCarryWidth = 12;
   localparam int EnergyWidth      = WordWidth + EnergyCarryWidth;
   localparam int TotalCarryWidth  = 2;
   localparam int TotalWidth       = WordWidth + TotalCarryWidth;
   localparam int QuotWidth        = WeightWidth;
   localparam int AddrWidth        = 5;
   localparam int IndexWidth       = 3;

   typedef enum logic [1:0] {
      MODE_ACTIVE = 2'd0,
      MODE_IDLE   = 2'd1,
      MODE_LIGHT  = 2'd2,
      MODE_DEEP   = 2'd3
   } mode_type;

   localparam logic [1:0] ACTION_MANAGE  = 2'd0;
   localparam logic [1:0] ACTION_GENERAL = 2'd1;
   localparam logic [1:0] ACTION_RF      = 2'd2;

   localparam logic [IndexWidth-1:0] REG_IDLE_AFTER    = 3'd0;
   localparam logic [IndexWidth-1:0] REG_LIGHT_AFTER   = 3'd1;
   localparam logic [IndexWidth-1:0] REG_DEEP_AFTER    = 3'd2;
   localparam logic [IndexWidth-1:0] REG_ACTIVE_WEIGHT = 3'd3;
   localparam logic [IndexWidth-1:0] REG_IDLE_WEIGHT   = 3'd4;
   localparam logic [IndexWidth-1:0] REG_SLEEP_WEIGHT  = 3'd5;

   typedef struct packed {
      logic [WordWidth-1:0]   idle_after;
      logic [WordWidth-1:0]   light_after;
      logic [WordWidth-1:0]   deep_after;
      logic [WeightWidth-1:0] active_weight;
      logic [WeightWidth-1:0] idle_weight;
      logic [WeightWidth-1:0] sleep_weight;
   } cfg_type;

   localparam cfg_type CfgReset = '{
      idle_after:    32'd5,
      light_after:   32'd30000,
      deep_after:    32'd300000,
      active_weight: 10'd30,
      idle_weight:   10'd15,
      sleep_weight:  10'd5
   };

   // One bit of each operand, LSB first
   typedef struct packed {
      logic now_b;
      logic act_b;
      logic rf_b;
      logic ent_b;
      logic deep_thr_b;
      logic light_thr_b;
      logic idle_thr_b;
      logic act_sum_b;
      logic idle_sum_b;
      logic sleep_sum_b;
   } ser_bits_type;

   // keep: totals as they stand; move: old mode's total plus time spent
   typedef struct packed {
      logic                   quiet_gt_deep;
      logic                   rf_gt_light;
      logic                   quiet_gt_idle;
      logic [EnergyWidth-1:0] energy_keep;
      logic [EnergyWidth-1:0] energy_move;
      logic [TotalWidth-1:0]  total_keep;
      logic [TotalWidth-1:0]  total_move;
      logic [WordWidth-1:0]   moved_total;
   } ser_result_type;

endpackage

>>> rtl/core/ipm_csr.sv
// APB-style configuration registers: thresholds and current weights.
// Depends on ipm_pkg.
module ipm_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [ipm_pkg::AddrWidth-1:0]    csr_paddr,
   input  logic [ipm_pkg::WordWidth-1:0]    csr_pwdata,
   output logic [ipm_pkg::WordWidth-1:0]    csr_prdata,
   output logic                             csr_pready,
   output ipm_pkg::cfg_type                 cfg
);

   ipm_pkg::cfg_type cfg_ff, cfg_in;
   logic [ipm_pkg::IndexWidth-1:0] index;
   logic write_en;

   assign index      = csr_paddr[ipm_pkg::AddrWidth-1:2];
   assign write_en   = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            ipm_pkg::REG_IDLE_AFTER:    cfg_in.idle_after  = csr_pwdata;
            ipm_pkg::REG_LIGHT_AFTER:   cfg_in.light_after = csr_pwdata;
            ipm_pkg::REG_DEEP_AFTER:    cfg_in.deep_after  = csr_pwdata;
            ipm_pkg::REG_ACTIVE_WEIGHT:
               cfg_in.active_weight = csr_pwdata[ipm_pkg::WeightWidth-1:0];
            ipm_pkg::REG_IDLE_WEIGHT:
               cfg_in.idle_weight = csr_pwdata[ipm_pkg::WeightWidth-1:0];
            ipm_pkg::REG_SLEEP_WEIGHT:
               cfg_in.sleep_weight = csr_pwdata[ipm_pkg::WeightWidth-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         ipm_pkg::REG_IDLE_AFTER:    csr_prdata = cfg_ff.idle_after;
         ipm_pkg::REG_LIGHT_AFTER:   csr_prdata = cfg_ff.light_after;
         ipm_pkg::REG_DEEP_AFTER:    csr_prdata = cfg_ff.deep_after;
         ipm_pkg::REG_ACTIVE_WEIGHT:
            csr_prdata = ipm_pkg::WordWidth'(cfg_ff.active_weight);
         ipm_pkg::REG_IDLE_WEIGHT:
            csr_prdata = ipm_pkg::WordWidth'(cfg_ff.idle_weight);
         ipm_pkg::REG_SLEEP_WEIGHT:
            csr_prdata = ipm_pkg::WordWidth'(cfg_ff.sleep_weight);
         default:                    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= ipm_pkg::CfgReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> rtl/core/ipm_serial.sv
// Bit-serial datapath: elapsed-time subtractors, threshold comparators,
// residency adder and weighted energy / total accumulators. Depends on ipm_pkg.
module ipm_serial (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               clear,
   input  logic                               step,
   input  ipm_pkg::mode_type                  old_mode,
   input  logic [ipm_pkg::WeightWidth-1:0]    active_weight,
   input  logic [ipm_pkg::WeightWidth-1:0]    idle_weight,
   input  logic [ipm_pkg::WeightWidth-1:0]    sleep_weight,
   input  ipm_pkg::ser_bits_type              bits,
   output ipm_pkg::ser_result_type            result
);

   localparam int AccWidth = ipm_pkg::EnergyCarryWidth + 1;
   localparam int TotAccWidth = ipm_pkg::TotalCarryWidth + 1;

   logic bq_ff, br_ff, bs_ff, cy_ff;
   logic gtd_ff, gtl_ff, gti_ff;
   logic bq_in, br_in, bs_in, cy_in;
   logic gtd_in, gtl_in, gti_in;
   logic [ipm_pkg::EnergyCarryWidth-1:0] ek_ff, em_ff;
   logic [ipm_pkg::TotalCarryWidth-1:0]  tk_ff, tm_ff;
   logic [ipm_pkg::WordWidth-1:0] elk_ff, elm_ff, tlk_ff, tlm_ff, moved_ff;

   logic quiet_b, rf_quiet_b, spent_b, old_b, sum_b;
   logic mv_act, mv_idle, mv_sleep;
   logic [AccWidth-1:0]    acc_keep, acc_move;
   logic [TotAccWidth-1:0] tot_keep, tot_move;

   function automatic logic borrow_out(input logic a, input logic b, input logic bin);
      borrow_out = (~a & b) | (~(a ^ b) & bin);
   endfunction

   function automatic logic greater(input logic a, input logic b, input logic gin);
      greater = (a & ~b) | (~(a ^ b) & gin);
   endfunction

   function automatic logic [AccWidth-1:0] weigh(
      input logic a, input logic i, input logic s,
      input logic [ipm_pkg::WeightWidth-1:0] wa,
      input logic [ipm_pkg::WeightWidth-1:0] wi,
      input logic [ipm_pkg::WeightWidth-1:0] ws
   );
      weigh = (a ? AccWidth'(wa) : '0) + (i ? AccWidth'(wi) : '0)
            + (s ? AccWidth'(ws) : '0);
   endfunction

   always_comb begin
      quiet_b    = bits.now_b ^ bits.act_b ^ bq_ff;
      rf_quiet_b = bits.now_b ^ bits.rf_b ^ br_ff;
      spent_b    = bits.now_b ^ bits.ent_b ^ bs_ff;
      bq_in = borrow_out(bits.now_b, bits.act_b, bq_ff);
      br_in = borrow_out(bits.now_b, bits.rf_b, br_ff);
      bs_in = borrow_out(bits.now_b, bits.ent_b, bs_ff);
      gtd_in = greater(quiet_b, bits.deep_thr_b, gtd_ff);
      gtl_in = greater(rf_quiet_b, bits.light_thr_b, gtl_ff);
      gti_in = greater(quiet_b, bits.idle_thr_b, gti_ff);

      mv_act   = bits.act_sum_b;
      mv_idle  = bits.idle_sum_b;
      mv_sleep = bits.sleep_sum_b;
      unique case (old_mode)
         ipm_pkg::MODE_ACTIVE: old_b = bits.act_sum_b;
         ipm_pkg::MODE_IDLE:   old_b = bits.idle_sum_b;
         default:              old_b = bits.sleep_sum_b;
      endcase
      sum_b = old_b ^ spent_b ^ cy_ff;
      cy_in = (old_b & spent_b) | (old_b & cy_ff) | (spent_b & cy_ff);
      unique case (old_mode)
         ipm_pkg::MODE_ACTIVE: mv_act  = sum_b;
         ipm_pkg::MODE_IDLE:   mv_idle = sum_b;
         default:              mv_sleep = sum_b;
      endcase

      acc_keep = AccWidth'(ek_ff) + weigh(bits.act_sum_b, bits.idle_sum_b,
                 bits.sleep_sum_b, active_weight, idle_weight, sleep_weight);
      acc_move = AccWidth'(em_ff) + weigh(mv_act, mv_idle, mv_sleep,
                 active_weight, idle_weight, sleep_weight);
      tot_keep = TotAccWidth'(tk_ff) + TotAccWidth'(bits.act_sum_b)
               + TotAccWidth'(bits.idle_sum_b) + TotAccWidth'(bits.sleep_sum_b);
      tot_move = TotAccWidth'(tm_ff) + TotAccWidth'(mv_act)
               + TotAccWidth'(mv_idle) + TotAccWidth'(mv_sleep);
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         bq_ff  <= 1'b0;
         br_ff  <= 1'b0;
         bs_ff  <= 1'b0;
         cy_ff  <= 1'b0;
         gtd_ff <= 1'b0;
         gtl_ff <= 1'b0;
         gti_ff <= 1'b0;
         ek_ff  <= '0;
         em_ff  <= '0;
         tk_ff  <= '0;
         tm_ff  <= '0;
      end else if (step) begin
         bq_ff  <= bq_in;
         br_ff  <= br_in;
         bs_ff  <= bs_in;
         cy_ff  <= cy_in;
         gtd_ff <= gtd_in;
         gtl_ff <= gtl_in;
         gti_ff <= gti_in;
         ek_ff  <= acc_keep[AccWidth-1:1];
         em_ff  <= acc_move[AccWidth-1:1];
         tk_ff  <= tot_keep[TotAccWidth-1:1];
         tm_ff  <= tot_move[TotAccWidth-1:1];
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         elk_ff   <= {acc_keep[0], elk_ff[ipm_pkg::WordWidth-1:1]};
         elm_ff   <= {acc_move[0], elm_ff[ipm_pkg::WordWidth-1:1]};
         tlk_ff   <= {tot_keep[0], tlk_ff[ipm_pkg::WordWidth-1:1]};
         tlm_ff   <= {tot_move[0], tlm_ff[ipm_pkg::WordWidth-1:1]};
         moved_ff <= {sum_b, moved_ff[ipm_pkg::WordWidth-1:1]};
      end
   end

   assign result.quiet_gt_deep = gtd_ff;
   assign result.rf_gt_light   = gtl_ff;
   assign result.quiet_gt_idle = gti_ff;
   assign result.energy_keep   = {ek_ff, elk_ff};
   assign result.energy_move   = {em_ff, elm_ff};
   assign result.total_keep    = {tk_ff, tlk_ff};
   assign result.total_move    = {tm_ff, tlm_ff};
   assign result.moved_total   = moved_ff;

endmodule

>>> rtl/core/ipm_divider.sv
// Restoring divider, one quotient bit per cycle, for the current estimate.
// Quotient is known to fit QuotWidth bits. Depends on ipm_pkg.
module ipm_divider (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [ipm_pkg::EnergyWidth-1:0]   dividend,
   input  logic [ipm_pkg::TotalWidth-1:0]    divisor,
   output logic                              done,
   output logic [ipm_pkg::QuotWidth-1:0]     quotient
);

   localparam int StepWidth = $clog2(ipm_pkg::QuotWidth + 1);
   localparam int QW = ipm_pkg::QuotWidth;
   localparam int TW = ipm_pkg::TotalWidth;

   logic [TW-1:0]        rem_ff, rem_in, div_ff;
   logic [QW-1:0]        low_ff, quot_ff;
   logic [StepWidth-1:0] cnt_ff;
   logic                 run_ff, done_ff;
   logic [TW:0]          ext, diff;
   logic                 ge;

   always_comb begin
      ext  = {rem_ff, low_ff[QW-1]};
      diff = ext - {1'b0, div_ff};
      ge   = ext >= {1'b0, div_ff};
      rem_in = ge ? diff[TW-1:0] : ext[TW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= !start && run_ff && (cnt_ff == StepWidth'(1));
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= StepWidth'(QW);
         end else if (run_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == StepWidth'(1)) begin
               run_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= dividend[ipm_pkg::EnergyWidth-1:QW];
         low_ff <= dividend[QW-1:0];
         div_ff <= divisor;
      end else if (run_ff) begin
         rem_ff  <= rem_in;
         low_ff  <= {low_ff[QW-2:0], 1'b0};
         quot_ff <= {quot_ff[QW-2:0], ge};
      end
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

>>> rtl/core/inactivity_power_mode_manager.sv
// Inactivity power mode manager top level: sequencer, rotating state words,
// result register. Depends on ipm_pkg, ipm_csr, ipm_serial, ipm_divider.
//
//   channel   direction  handshake              payload
//   req_      in         req_valid / req_stall  req_action, req_now_ms
//   rsp_      out        rsp_valid / rsp_stall  mode, changed, estimate, three totals
//   csr_      in/out     APB psel/penable       6 registers at 4*index
//
// An item is worked bit-serially over all 32-bit words, then passes a decide step,
// the divider (ten quotient bits and a done strobe; skipped when all totals
// are zero) and the result state; the next transaction is taken once the
// sequencer is back in its idle state.
// Reset (synchronous) restores register defaults and clears mode, stamps, totals.
// A stalled result holds in rsp_; one more item may be worked meanwhile, and
// it waits in its result state until the register is free.
module inactivity_power_mode_manager (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_action,
   input  logic [ipm_pkg::WordWidth-1:0]   req_now_ms,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [1:0]                      rsp_mode,
   output logic                            rsp_mode_changed,
   output logic [ipm_pkg::WeightWidth-1:0] rsp_estimate_ma,
   output logic [ipm_pkg::WordWidth-1:0]   rsp_active_total_ms,
   output logic [ipm_pkg::WordWidth-1:0]   rsp_idle_total_ms,
   output logic [ipm_pkg::WordWidth-1:0]   rsp_sleep_total_ms,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [ipm_pkg::AddrWidth-1:0]   csr_paddr,
   input  logic [ipm_pkg::WordWidth-1:0]   csr_pwdata,
   output logic [ipm_pkg::WordWidth-1:0]   csr_prdata,
   output logic                            csr_pready
);

   localparam int WW = ipm_pkg::WordWidth;
   localparam int CW = ipm_pkg::CountWidth;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_DECIDE,
      ST_DIVIDE,
      ST_WRITE
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [1:0] action_ff, action_in;
   logic [WW-1:0] now_ff, now_in, act_at_ff, act_at_in, rf_at_ff, rf_at_in;
   logic [WW-1:0] ent_at_ff, ent_at_in;
   logic [WW-1:0] act_sum_ff, act_sum_in, idle_sum_ff, idle_sum_in;
   logic [WW-1:0] sleep_sum_ff, sleep_sum_in;
   logic [WW-1:0] deep_sr_ff, deep_sr_in, light_sr_ff, light_sr_in;
   logic [WW-1:0] idle_sr_ff, idle_sr_in;
   ipm_pkg::mode_type mode_ff, mode_in, target;
   logic changed_ff, changed_in, changed;
   logic [ipm_pkg::WeightWidth-1:0] est_ff, est_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_mode_ff, rsp_mode_in;
   logic rsp_changed_ff, rsp_changed_in;
   logic [ipm_pkg::WeightWidth-1:0] rsp_est_ff, rsp_est_in;
   logic [WW-1:0] rsp_act_ff, rsp_act_in, rsp_idle_ff, rsp_idle_in;
   logic [WW-1:0] rsp_sleep_ff, rsp_sleep_in;

   ipm_pkg::cfg_type cfg;
   ipm_pkg::ser_bits_type bits;
   ipm_pkg::ser_result_type ser;
   logic ser_clear, ser_step, div_start, div_done;
   logic [ipm_pkg::EnergyWidth-1:0] sel_energy;
   logic [ipm_pkg::TotalWidth-1:0] sel_total;
   logic [ipm_pkg::QuotWidth-1:0] quotient;
   logic [ipm_pkg::WeightWidth-1:0] max_weight;

   ipm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign bits.now_b       = now_ff[0];
   assign bits.act_b       = act_at_ff[0];
   assign bits.rf_b        = rf_at_ff[0];
   assign bits.ent_b       = ent_at_ff[0];
   assign bits.deep_thr_b  = deep_sr_ff[0];
   assign bits.light_thr_b = light_sr_ff[0];
   assign bits.idle_thr_b  = idle_sr_ff[0];
   assign bits.act_sum_b   = act_sum_ff[0];
   assign bits.idle_sum_b  = idle_sum_ff[0];
   assign bits.sleep_sum_b = sleep_sum_ff[0];

   ipm_serial u_serial (
      .clock         (clock),
      .reset         (reset),
      .clear         (ser_clear),
      .step          (ser_step),
      .old_mode      (mode_ff),
      .active_weight (cfg.active_weight),
      .idle_weight   (cfg.idle_weight),
      .sleep_weight  (cfg.sleep_weight),
      .bits          (bits),
      .result        (ser)
   );

   ipm_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sel_energy),
      .divisor  (sel_total),
      .done     (div_done),
      .quotient (quotient)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign ser_step  = (state_ff == ST_SHIFT);

   always_comb begin
      priority if (ser.quiet_gt_deep)  target = ipm_pkg::MODE_DEEP;
      else if (ser.rf_gt_light)         target = ipm_pkg::MODE_LIGHT;
      else if (ser.quiet_gt_idle)       target = ipm_pkg::MODE_IDLE;
      else                              target = ipm_pkg::MODE_ACTIVE;
      unique case (action_ff)
         ipm_pkg::ACTION_MANAGE:  ;
         ipm_pkg::ACTION_GENERAL: target = ipm_pkg::MODE_ACTIVE;
         ipm_pkg::ACTION_RF:      target = ipm_pkg::MODE_ACTIVE;
         default:                 target = mode_ff;
      endcase
      changed    = (target != mode_ff);
      sel_energy = changed ? ser.energy_move : ser.energy_keep;
      sel_total  = changed ? ser.total_move : ser.total_keep;
   end

   always_comb begin
      max_weight = cfg.active_weight;
      if (cfg.idle_weight > max_weight) max_weight = cfg.idle_weight;
      if (cfg.sleep_weight > max_weight) max_weight = cfg.sleep_weight;
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      action_in    = action_ff;
      now_in       = now_ff;
      act_at_in    = act_at_ff;
      rf_at_in     = rf_at_ff;
      ent_at_in    = ent_at_ff;
      act_sum_in   = act_sum_ff;
      idle_sum_in  = idle_sum_ff;
      sleep_sum_in = sleep_sum_ff;
      deep_sr_in   = deep_sr_ff;
      light_sr_in  = light_sr_ff;
      idle_sr_in   = idle_sr_ff;
      mode_in      = mode_ff;
      changed_in   = changed_ff;
      est_in       = est_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_mode_in    = rsp_mode_ff;
      rsp_changed_in = rsp_changed_ff;
      rsp_est_in     = rsp_est_ff;
      rsp_act_in     = rsp_act_ff;
      rsp_idle_in    = rsp_idle_ff;
      rsp_sleep_in   = rsp_sleep_ff;
      ser_clear = 1'b0;
      div_start = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               action_in   = req_action;
               now_in      = req_now_ms;
               deep_sr_in  = cfg.deep_after;
               light_sr_in = cfg.light_after;
               idle_sr_in  = cfg.idle_after;
               cnt_in      = '0;
               ser_clear   = 1'b1;
               state_in    = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            now_in       = {now_ff[0], now_ff[WW-1:1]};
            act_at_in    = {act_at_ff[0], act_at_ff[WW-1:1]};
            rf_at_in     = {rf_at_ff[0], rf_at_ff[WW-1:1]};
            ent_at_in    = {ent_at_ff[0], ent_at_ff[WW-1:1]};
            act_sum_in   = {act_sum_ff[0], act_sum_ff[WW-1:1]};
            idle_sum_in  = {idle_sum_ff[0], idle_sum_ff[WW-1:1]};
            sleep_sum_in = {sleep_sum_ff[0], sleep_sum_ff[WW-1:1]};
            deep_sr_in   = {1'b0, deep_sr_ff[WW-1:1]};
            light_sr_in  = {1'b0, light_sr_ff[WW-1:1]};
            idle_sr_in   = {1'b0, idle_sr_ff[WW-1:1]};
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CW'(WW - 1)) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (action_ff == ipm_pkg::ACTION_RF) begin
               rf_at_in  = now_ff;
               act_at_in = now_ff;
            end else if (action_ff == ipm_pkg::ACTION_GENERAL) begin
               act_at_in = now_ff;
            end
            changed_in = changed;
            if (changed) begin
               mode_in   = target;
               ent_at_in = now_ff;
               unique case (mode_ff)
                  ipm_pkg::MODE_ACTIVE: act_sum_in  = ser.moved_total;
                  ipm_pkg::MODE_IDLE:   idle_sum_in = ser.moved_total;
                  default:              sleep_sum_in = ser.moved_total;
               endcase
            end
            if (sel_total == '0) begin
               est_in   = cfg.active_weight;
               state_in = ST_WRITE;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               est_in   = quotient;
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_mode_in    = mode_ff;
               rsp_changed_in = changed_ff;
               rsp_est_in     = est_ff;
               rsp_act_in     = act_sum_ff;
               rsp_idle_in    = idle_sum_ff;
               rsp_sleep_in   = sleep_sum_ff;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         mode_ff      <= ipm_pkg::MODE_ACTIVE;
         act_at_ff    <= '0;
         rf_at_ff     <= '0;
         ent_at_ff    <= '0;
         act_sum_ff   <= '0;
         idle_sum_ff  <= '0;
         sleep_sum_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         mode_ff      <= mode_in;
         act_at_ff    <= act_at_in;
         rf_at_ff     <= rf_at_in;
         ent_at_ff    <= ent_at_in;
         act_sum_ff   <= act_sum_in;
         idle_sum_ff  <= idle_sum_in;
         sleep_sum_ff <= sleep_sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      action_ff      <= action_in;
      now_ff         <= now_in;
      deep_sr_ff     <= deep_sr_in;
      light_sr_ff    <= light_sr_in;
      idle_sr_ff     <= idle_sr_in;
      changed_ff     <= changed_in;
      est_ff         <= est_in;
      rsp_mode_ff    <= rsp_mode_in;
      rsp_changed_ff <= rsp_changed_in;
      rsp_est_ff     <= rsp_est_in;
      rsp_act_ff     <= rsp_act_in;
      rsp_idle_ff    <= rsp_idle_in;
      rsp_sleep_ff   <= rsp_sleep_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_mode            = rsp_mode_ff;
   assign rsp_mode_changed    = rsp_changed_ff;
   assign rsp_estimate_ma     = rsp_est_ff;
   assign rsp_active_total_ms = rsp_act_ff;
   assign rsp_idle_total_ms   = rsp_idle_ff;
   assign rsp_sleep_total_ms  = rsp_sleep_ff;

   a_rsp_from_write: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_WRITE))
      else $error("result raised outside the write cycle");

   a_change_moves_mode: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE && changed) |=> (mode_ff != $past(mode_ff)))
      else $error("mode change flagged but mode held");

   a_div_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIVIDE))
      else $error("divider finished outside divide state");

   a_estimate_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE && div_done) |=> (est_ff <= $past(max_weight)))
      else $error("estimate above largest weight");

endmodule

>>> verif/ipm_checker.sv
// Checker for the inactivity power mode manager: watches the request, result
// and register channels, predicts each result and compares it field by field.
// Depends on ipm_pkg.
module ipm_checker
   import ipm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic [1:0]             req_action,
   input  logic [WordWidth-1:0]   req_now_ms,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic [1:0]             rsp_mode,
   input  logic                   rsp_mode_changed,
   input  logic [WeightWidth-1:0] rsp_estimate_ma,
   input  logic [WordWidth-1:0]   rsp_active_total_ms,
   input  logic [WordWidth-1:0]   rsp_idle_total_ms,
   input  logic [WordWidth-1:0]   rsp_sleep_total_ms,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [AddrWidth-1:0]   csr_paddr,
   input  logic [WordWidth-1:0]   csr_pwdata,
   input  logic [WordWidth-1:0]   csr_prdata,
   input  logic                   csr_pready,
   output int                     failures,
   output int                     outstanding,
   output int                     results_seen
);

   typedef struct {
      mode_type               mode;
      logic                   changed;
      logic [WeightWidth-1:0] estimate;
      logic [WordWidth-1:0]   active_total;
      logic [WordWidth-1:0]   idle_total;
      logic [WordWidth-1:0]   sleep_total;
   } mode_report_type;

   mode_report_type expected_reports[$];

   mode_type               cur_mode;
   logic [WordWidth-1:0]   entered_at;
   logic [WordWidth-1:0]   activity_at;
   logic [WordWidth-1:0]   rf_activity_at;
   logic [WordWidth-1:0]   active_sum;
   logic [WordWidth-1:0]   idle_sum;
   logic [WordWidth-1:0]   sleep_sum;

   logic [WordWidth-1:0]   idle_limit;
   logic [WordWidth-1:0]   light_limit;
   logic [WordWidth-1:0]   deep_limit;
   logic [WeightWidth-1:0] active_ma;
   logic [WeightWidth-1:0] idle_ma;
   logic [WeightWidth-1:0] sleep_ma;

   int fail_count = 0;
   int queued     = 0;
   int seen       = 0;

   assign failures     = fail_count;
   assign outstanding  = queued;
   assign results_seen = seen;

   task automatic report_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      fail_count++;
   endtask

   function automatic logic [WordWidth-1:0] register_value(input logic [IndexWidth-1:0] index);
      case (index)
         REG_IDLE_AFTER:    return idle_limit;
         REG_LIGHT_AFTER:   return light_limit;
         REG_DEEP_AFTER:    return deep_limit;
         REG_ACTIVE_WEIGHT: return WordWidth'(active_ma);
         REG_IDLE_WEIGHT:   return WordWidth'(idle_ma);
         REG_SLEEP_WEIGHT:  return WordWidth'(sleep_ma);
         default:           return '0;
      endcase
   endfunction

   // residency of the mode being left goes to its total; sleep modes share one
   function automatic bit switch_to(input mode_type target, input logic [WordWidth-1:0] now);
      logic [WordWidth-1:0] spent;
      if (target == cur_mode)
         return 1'b0;
      spent = now - entered_at;
      case (cur_mode)
         MODE_ACTIVE: active_sum += spent;
         MODE_IDLE:   idle_sum   += spent;
         default:     sleep_sum  += spent;
      endcase
      cur_mode   = target;
      entered_at = now;
      return 1'b1;
   endfunction

   function automatic logic [WeightWidth-1:0] average_current();
      logic [WordWidth+1:0] span;
      logic [63:0]          charge;
      span = (WordWidth+2)'(active_sum) + (WordWidth+2)'(idle_sum) + (WordWidth+2)'(sleep_sum);
      if (span == '0)
         return active_ma;
      charge = 64'(active_sum) * 64'(active_ma)
             + 64'(idle_sum) * 64'(idle_ma)
             + 64'(sleep_sum) * 64'(sleep_ma);
      return WeightWidth'(charge / 64'(span));
   endfunction

   task automatic predict_transaction(input logic [1:0] action, input logic [WordWidth-1:0] now);
      mode_report_type      report;
      logic [WordWidth-1:0] quiet;
      logic [WordWidth-1:0] rf_quiet;
      mode_type             target;
      bit                   changed;
      changed = 1'b0;
      case (action)
         ACTION_RF: begin
            rf_activity_at = now;
            activity_at    = now;
            changed        = switch_to(MODE_ACTIVE, now);
         end
         ACTION_GENERAL: begin
            activity_at = now;
            changed     = switch_to(MODE_ACTIVE, now);
         end
         ACTION_MANAGE: begin
            quiet    = now - activity_at;
            rf_quiet = now - rf_activity_at;
            if (quiet > deep_limit)
               target = MODE_DEEP;
            else if (rf_quiet > light_limit)
               target = MODE_LIGHT;
            else if (quiet > idle_limit)
               target = MODE_IDLE;
            else
               target = MODE_ACTIVE;
            changed = switch_to(target, now);
         end
         default: ;
      endcase
      report.mode         = cur_mode;
      report.changed      = changed;
      report.estimate     = average_current();
      report.active_total = active_sum;
      report.idle_total   = idle_sum;
      report.sleep_total  = sleep_sum;
      expected_reports.push_back(report);
   endtask

   task automatic check_result();
      mode_report_type want;
      if (expected_reports.size() == 0) begin
         report_mismatch("result transaction with no request outstanding");
         return;
      end
      want = expected_reports.pop_front();
      seen++;
      if (rsp_mode !== want.mode)
         report_mismatch($sformatf("mode got %0d want %0d", rsp_mode, want.mode));
      if (rsp_mode_changed !== want.changed)
         report_mismatch($sformatf("mode_changed got %0d want %0d",
                                   rsp_mode_changed, want.changed));
      if (rsp_estimate_ma !== want.estimate)
         report_mismatch($sformatf("estimate_ma got %0d want %0d",
                                   rsp_estimate_ma, want.estimate));
      if (rsp_active_total_ms !== want.active_total)
         report_mismatch($sformatf("active_total_ms got %0d want %0d",
                                   rsp_active_total_ms, want.active_total));
      if (rsp_idle_total_ms !== want.idle_total)
         report_mismatch($sformatf("idle_total_ms got %0d want %0d",
                                   rsp_idle_total_ms, want.idle_total));
      if (rsp_sleep_total_ms !== want.sleep_total)
         report_mismatch($sformatf("sleep_total_ms got %0d want %0d",
                                   rsp_sleep_total_ms, want.sleep_total));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         idle_limit     = 32'd5;
         light_limit    = 32'd30000;
         deep_limit     = 32'd300000;
         active_ma      = 10'd30;
         idle_ma        = 10'd15;
         sleep_ma       = 10'd5;
         cur_mode       = MODE_ACTIVE;
         entered_at     = '0;
         activity_at    = '0;
         rf_activity_at = '0;
         active_sum     = '0;
         idle_sum       = '0;
         sleep_sum      = '0;
         expected_reports.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               case (csr_paddr[AddrWidth-1:2])
                  REG_IDLE_AFTER:    idle_limit  = csr_pwdata;
                  REG_LIGHT_AFTER:   light_limit = csr_pwdata;
                  REG_DEEP_AFTER:    deep_limit  = csr_pwdata;
                  REG_ACTIVE_WEIGHT: active_ma   = csr_pwdata[WeightWidth-1:0];
                  REG_IDLE_WEIGHT:   idle_ma     = csr_pwdata[WeightWidth-1:0];
                  REG_SLEEP_WEIGHT:  sleep_ma    = csr_pwdata[WeightWidth-1:0];
                  default: ;
               endcase
            end else if (csr_paddr[AddrWidth-1:2] <= REG_SLEEP_WEIGHT &&
                         csr_prdata !== register_value(csr_paddr[AddrWidth-1:2])) begin
               report_mismatch($sformatf("register %0d read %0h want %0h",
                               csr_paddr[AddrWidth-1:2], csr_prdata,
                               register_value(csr_paddr[AddrWidth-1:2])));
            end
         end
         if (rsp_valid && !rsp_stall)
            check_result();
         if (req_valid && !req_stall)
            predict_transaction(req_action, req_now_ms);
      end
      queued <= expected_reports.size();
   end

endmodule

>>> verif/tb_inactivity_power_mode_manager.sv
// Testbench top for the inactivity power mode manager: clock, reset, request
// and register stimulus, result-side stalls and the verdict.
// Depends on ipm_pkg, inactivity_power_mode_manager and ipm_checker.
module tb_inactivity_power_mode_manager;
   import ipm_pkg::*;

   localparam logic [1:0]            ACTION_UNUSED = 2'd3;
   localparam logic [IndexWidth-1:0] REG_UNUSED    = 3'd6;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [1:0]             req_action = ACTION_MANAGE;
   logic [WordWidth-1:0]   req_now_ms = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [1:0]             rsp_mode;
   logic                   rsp_mode_changed;
   logic [WeightWidth-1:0] rsp_estimate_ma;
   logic [WordWidth-1:0]   rsp_active_total_ms;
   logic [WordWidth-1:0]   rsp_idle_total_ms;
   logic [WordWidth-1:0]   rsp_sleep_total_ms;
   logic                   csr_psel = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite = 1'b0;
   logic [AddrWidth-1:0]   csr_paddr = '0;
   logic [WordWidth-1:0]   csr_pwdata = '0;
   logic [WordWidth-1:0]   csr_prdata;
   logic                   csr_pready;

   int failures;
   int outstanding;
   int results_seen;
   int idle_pct = 0;
   int stall_pct = 0;
   int items_sent = 0;
   int settings_used = 0;
   logic [WordWidth-1:0] stamp_ms = '0;

   int idle_mix[4]  = '{0, 47, 0, 30};
   int stall_mix[4] = '{0, 0, 47, 30};

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock)
      rsp_stall <= ($urandom_range(99) < stall_pct);

   inactivity_power_mode_manager u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_action          (req_action),
      .req_now_ms          (req_now_ms),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_mode            (rsp_mode),
      .rsp_mode_changed    (rsp_mode_changed),
      .rsp_estimate_ma     (rsp_estimate_ma),
      .rsp_active_total_ms (rsp_active_total_ms),
      .rsp_idle_total_ms   (rsp_idle_total_ms),
      .rsp_sleep_total_ms  (rsp_sleep_total_ms),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .csr_pready          (csr_pready)
   );

   ipm_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_action          (req_action),
      .req_now_ms          (req_now_ms),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_mode            (rsp_mode),
      .rsp_mode_changed    (rsp_mode_changed),
      .rsp_estimate_ma     (rsp_estimate_ma),
      .rsp_active_total_ms (rsp_active_total_ms),
      .rsp_idle_total_ms   (rsp_idle_total_ms),
      .rsp_sleep_total_ms  (rsp_sleep_total_ms),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .csr_pready          (csr_pready),
      .failures            (failures),
      .outstanding         (outstanding),
      .results_seen        (results_seen)
   );

   task automatic send_item(input logic [1:0] action, input logic [WordWidth-1:0] now);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_action <= action;
      req_now_ms <= now;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   // hold off new requests until every outstanding transaction has returned
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_access(input bit is_write, input logic [IndexWidth-1:0] index,
                             input logic [WordWidth-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic read_back_all();
      for (int i = int'(REG_IDLE_AFTER); i <= int'(REG_SLEEP_WEIGHT); i++)
         csr_access(1'b0, IndexWidth'(i), '0);
   endtask

   task automatic program_registers(input logic [WordWidth-1:0] idle_ms,
                                    input logic [WordWidth-1:0] light_ms,
                                    input logic [WordWidth-1:0] deep_ms,
                                    input logic [WeightWidth-1:0] act_w,
                                    input logic [WeightWidth-1:0] idle_w,
                                    input logic [WeightWidth-1:0] sleep_w);
      csr_access(1'b1, REG_IDLE_AFTER, idle_ms);
      csr_access(1'b1, REG_LIGHT_AFTER, light_ms);
      csr_access(1'b1, REG_DEEP_AFTER, deep_ms);
      csr_access(1'b1, REG_ACTIVE_WEIGHT, {$urandom} & ~32'h3ff | WordWidth'(act_w));
      csr_access(1'b1, REG_IDLE_WEIGHT, {$urandom} & ~32'h3ff | WordWidth'(idle_w));
      csr_access(1'b1, REG_SLEEP_WEIGHT, {$urandom} & ~32'h3ff | WordWidth'(sleep_w));
      read_back_all();
      settings_used++;
   endtask

   function automatic logic [WordWidth-1:0] pick_limit(input int typical);
      if ($urandom_range(7) == 0)
         return $urandom;
      return $urandom_range(typical);
   endfunction

   function automatic logic [WordWidth-1:0] pick_step();
      int roll;
      roll = $urandom_range(99);
      if (roll < 50)
         return $urandom_range(20);
      else if (roll < 80)
         return $urandom_range(600);
      else if (roll < 95)
         return $urandom_range(5000);
      return $urandom;
   endfunction

   function automatic logic [1:0] pick_action();
      int roll;
      roll = $urandom_range(99);
      if (roll < 60)
         return ACTION_MANAGE;
      else if (roll < 80)
         return ACTION_GENERAL;
      else if (roll < 95)
         return ACTION_RF;
      return ACTION_UNUSED;
   endfunction

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      read_back_all();

      // reset thresholds: strict compares, each mode, wrap of the timestamp
      send_item(ACTION_MANAGE, 32'd0);
      send_item(ACTION_MANAGE, 32'd5);
      send_item(ACTION_MANAGE, 32'd6);
      send_item(ACTION_GENERAL, 32'd10);
      send_item(ACTION_MANAGE, 32'd30011);
      send_item(ACTION_RF, 32'd30020);
      send_item(ACTION_MANAGE, 32'd330021);
      send_item(ACTION_MANAGE, 32'd330030);
      send_item(ACTION_UNUSED, 32'hffff_ffff);
      send_item(ACTION_GENERAL, 32'hffff_ffff);
      send_item(ACTION_MANAGE, 32'd2);
      send_item(ACTION_MANAGE, 32'h7fff_ffff);
      drain();

      program_registers('0, '1, '1, 10'h3ff, 10'h000, 10'h3ff);
      csr_access(1'b1, REG_UNUSED, '1);
      read_back_all();
      send_item(ACTION_GENERAL, 32'd1000);
      send_item(ACTION_MANAGE, 32'd1000);
      send_item(ACTION_MANAGE, 32'd1001);
      send_item(ACTION_MANAGE, 32'd999);
      drain();

      program_registers('0, '0, '0, 10'h000, 10'h000, 10'h000);
      send_item(ACTION_RF, 32'd50);
      send_item(ACTION_MANAGE, 32'd50);
      send_item(ACTION_GENERAL, 32'd60);
      send_item(ACTION_MANAGE, 32'd60);
      send_item(ACTION_MANAGE, 32'd61);
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         idle_pct  = idle_mix[phase];
         stall_pct = stall_mix[phase];
         program_registers(pick_limit(40), pick_limit(400), pick_limit(3000),
                           WeightWidth'($urandom_range(1023)),
                           WeightWidth'($urandom_range(1023)),
                           WeightWidth'($urandom_range(1023)));
         for (int n = 0; n < 250; n++) begin
            if (n == 125)
               drain();
            stamp_ms += pick_step();
            send_item(pick_action(), stamp_ms);
         end
         drain();
      end

      idle_pct  = 0;
      stall_pct = 0;
      repeat (60) @(posedge clock);
      $display("Sent %0d transactions, checked %0d results", items_sent, results_seen);
      $display("across %0d register settings and four idle/stall patterns", settings_used);
      if (failures == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #2000000;
      $display("Some tests failed");
      $finish;
   end

endmodule
